### hw/rtl/lcd4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and constants of the 4-bit character LCD sequencer
// Request codes, pin phase codes, controller states and the step scripts
// of the clear and power-up operations.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    localparam int ModeW   = 3;
    localparam int StepW   = 5;
    localparam int WaitMsW = 6;
    localparam int HoldW   = 16;

    localparam logic [ModeW-1:0] MODE_CMD    = 3'd0;
    localparam logic [ModeW-1:0] MODE_DATA   = 3'd1;
    localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd2;
    localparam logic [ModeW-1:0] MODE_CURSOR = 3'd3;
    localparam logic [ModeW-1:0] MODE_INIT   = 3'd4;

    localparam logic CFG_SETUP  = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    localparam logic [7:0] SETUP_US_RST  = 8'd5;
    localparam logic [7:0] ENABLE_US_RST = 8'd20;
    localparam logic [HoldW-1:0] US_PER_MS = 16'd1000;

    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    typedef enum logic [1:0] {
        PH_SETUP,
        PH_EN_HI,
        PH_EN_LO,
        PH_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SETUP,
        ST_EN_HI,
        ST_EN_LO,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic               is_wait;
        logic               use_input;
        logic [7:0]         byte_val;
        logic [WaitMsW-1:0] wait_ms;
        logic               is_final;
    } op_t;

    typedef struct packed {
        logic               load;
        logic               emit;
        phase_t             phase;
        logic               sel;
        logic               half;
        logic               use_input;
        logic [7:0]         table_byte;
        logic [WaitMsW-1:0] wait_ms;
        logic               last;
    } lcd4_cmd_t;

    typedef struct packed {
        logic out_free;
    } lcd4_status_t;

    function automatic op_t byte_op(input logic [7:0] b, input logic fin);
        op_t op;
        op          = '0;
        op.byte_val = b;
        op.is_final = fin;
        return op;
    endfunction

    function automatic op_t wait_op(input logic [WaitMsW-1:0] ms, input logic fin);
        op_t op;
        op          = '0;
        op.is_wait  = 1'b1;
        op.wait_ms  = ms;
        op.is_final = fin;
        return op;
    endfunction

    function automatic op_t script_op(input logic [ModeW-1:0] mode,
                                      input logic [StepW-1:0] idx);
        op_t op;
        op = '0;
        case (mode) inside
            MODE_CMD, MODE_DATA, MODE_CURSOR:
            begin
                op.use_input = 1'b1;
                op.is_final  = 1'b1;
            end
            MODE_CLEAR:
            begin
                if (idx == '0)
                    op = byte_op(8'h01, 1'b0);
                else
                    op = wait_op(6'd2, 1'b1);
            end
            MODE_INIT:
            begin
                case (idx)
                    5'd0:    op = wait_op(6'd50, 1'b0);
                    5'd1:    op = byte_op(8'h30, 1'b0);
                    5'd2:    op = wait_op(6'd5, 1'b0);
                    5'd3:    op = byte_op(8'h30, 1'b0);
                    5'd4:    op = wait_op(6'd1, 1'b0);
                    5'd5:    op = byte_op(8'h30, 1'b0);
                    5'd6:    op = wait_op(6'd10, 1'b0);
                    5'd7:    op = byte_op(8'h20, 1'b0);
                    5'd8:    op = wait_op(6'd10, 1'b0);
                    5'd9:    op = byte_op(8'h28, 1'b0);
                    5'd10:   op = wait_op(6'd1, 1'b0);
                    5'd11:   op = byte_op(8'h08, 1'b0);
                    5'd12:   op = wait_op(6'd1, 1'b0);
                    5'd13:   op = byte_op(8'h01, 1'b0);
                    5'd14:   op = wait_op(6'd2, 1'b0);
                    5'd15:   op = byte_op(8'h06, 1'b0);
                    5'd16:   op = wait_op(6'd1, 1'b0);
                    5'd17:   op = byte_op(8'h0C, 1'b1);
                    default: op = wait_op(6'd0, 1'b1);
                endcase
            end
            default:
            begin
                op = '0;
            end
        endcase
        return op;
    endfunction

endpackage

### hw/rtl/lcd4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_ctrl: request sequencer of the 4-bit character LCD interface
// Walks the step script of one request and issues one pin phase per beat.
// ----------------------------------------------------------------------------
module lcd4_ctrl
    import lcd4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [ModeW-1:0]   req_mode,
    output logic               req_ready,
    input  lcd4_status_t       status,
    output lcd4_cmd_t          cmd
);

    state_t             state_reg, state_next;
    logic [ModeW-1:0]   mode_reg, mode_next;
    logic [StepW-1:0]   idx_reg, idx_next;
    logic               half_reg, half_next;
    op_t                op;
    logic               accept;
    logic               mode_ok;

    assign op        = script_op(mode_reg, idx_reg);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign mode_ok   = (req_mode == MODE_CMD) || (req_mode == MODE_DATA) ||
                       (req_mode == MODE_CLEAR) || (req_mode == MODE_CURSOR) ||
                       (req_mode == MODE_INIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_CMD;
            idx_reg   <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        half_next  = half_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode_ok)
                begin
                    mode_next  = req_mode;
                    idx_next   = '0;
                    half_next  = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = op.is_wait ? ST_WAIT : ST_SETUP;
            end
            ST_SETUP:
            begin
                if (status.out_free)
                    state_next = ST_EN_HI;
            end
            ST_EN_HI:
            begin
                if (status.out_free)
                    state_next = ST_EN_LO;
            end
            ST_EN_LO:
            begin
                if (status.out_free)
                begin
                    if (!half_reg)
                    begin
                        half_next  = 1'b1;
                        state_next = ST_SETUP;
                    end
                    else if (op.is_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        half_next  = 1'b0;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    if (op.is_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.load       = accept;
        cmd.sel        = (mode_reg == MODE_DATA);
        cmd.half       = half_reg;
        cmd.use_input  = op.use_input;
        cmd.table_byte = op.byte_val;
        cmd.wait_ms    = op.wait_ms;
        cmd.phase      = PH_SETUP;
        unique case (state_reg)
            ST_IDLE, ST_FETCH:
            begin
                cmd.emit = 1'b0;
            end
            ST_SETUP:
            begin
                cmd.emit  = status.out_free;
                cmd.phase = PH_SETUP;
            end
            ST_EN_HI:
            begin
                cmd.emit  = status.out_free;
                cmd.phase = PH_EN_HI;
            end
            ST_EN_LO:
            begin
                cmd.emit  = status.out_free;
                cmd.phase = PH_EN_LO;
                cmd.last  = half_reg && op.is_final;
            end
            ST_WAIT:
            begin
                cmd.emit  = status.out_free;
                cmd.phase = PH_WAIT;
                cmd.last  = op.is_final;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lcd4_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_datapath: pin levels, timing registers and result register
// Holds the pins now driven, the byte in flight and the outgoing beat.
// ----------------------------------------------------------------------------
module lcd4_datapath
    import lcd4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lcd4_cmd_t          cmd,
    output lcd4_status_t       status,
    input  logic [ModeW-1:0]   req_mode,
    input  logic [7:0]         req_value,
    input  logic [1:0]         req_row,
    input  logic [6:0]         req_col,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast
);

    logic [7:0]       setup_us_reg;
    logic [7:0]       enable_us_reg;
    logic             held_select_reg;
    logic [3:0]       held_nibble_reg;
    logic [7:0]       in_byte_reg;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             m_tlast_reg;

    logic [7:0]       cur_byte;
    logic [3:0]       cur_nibble;
    logic             out_select;
    logic [3:0]       out_nibble;
    logic             out_enable;
    logic [HoldW-1:0] out_hold;

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign cur_byte   = cmd.use_input ? in_byte_reg : cmd.table_byte;
    assign cur_nibble = cmd.half ? cur_byte[3:0] : cur_byte[7:4];

    always_comb
    begin
        out_select = held_select_reg;
        out_nibble = held_nibble_reg;
        out_enable = 1'b0;
        out_hold   = {8'd0, enable_us_reg};
        case (cmd.phase)
            PH_SETUP:
            begin
                out_select = cmd.sel;
                out_hold   = {8'd0, setup_us_reg};
            end
            PH_EN_HI:
            begin
                out_nibble = cur_nibble;
                out_enable = 1'b1;
            end
            PH_EN_LO:
            begin
                out_hold = {8'd0, enable_us_reg};
            end
            PH_WAIT:
            begin
                out_hold = HoldW'({{(HoldW-WaitMsW){1'b0}}, cmd.wait_ms} * US_PER_MS);
            end
            default:
            begin
                out_hold = {8'd0, enable_us_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_us_reg    <= SETUP_US_RST;
            enable_us_reg   <= ENABLE_US_RST;
            held_select_reg <= 1'b0;
            held_nibble_reg <= 4'd0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SETUP)
                    setup_us_reg <= cfg_data;
                else
                    enable_us_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                held_select_reg <= out_select;
                held_nibble_reg <= out_nibble;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: byte in flight and outgoing beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (req_mode == MODE_CURSOR)
                in_byte_reg <= ROW_BASE[req_row] | {1'b0, req_col};
            else
                in_byte_reg <= req_value;
        end
        if (cmd.emit)
        begin
            m_tdata_reg <= {2'b00, out_hold, out_enable, out_nibble, out_select};
            m_tlast_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### hw/rtl/char_lcd_four_bit_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_four_bit_write_sequencer: 4-bit character LCD write sequencer
// Turns LCD requests into timed pin phases for an external phase timer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per request (command byte, data byte, clear,
//   set cursor, power-up sequence). Master stream: one beat per pin phase
//   with the levels of select, D7..D4 and enable plus the hold time in us;
//   tlast marks the final phase of a request.
//   Config channel: index 0 writes setup_us, index 1 writes enable_us.
//   Write only while no request is in flight.
// Timing:
//   A request is accepted in the idle state, then each script step passes
//   through the controller's fetch state, then issues one phase beat per
//   cycle while the output register is free. A byte is six phases, clear
//   seven, the power-up sequence 18 steps / 63 phases. The controller
//   handles one request at a time.
// Reset: timing registers return to 5 us and 20 us, held pins go low.
// Stall: a stalled master beat holds its register and the controller waits.
// ----------------------------------------------------------------------------
module char_lcd_four_bit_write_sequencer
    import lcd4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[2:0], value[10:3], row[12:11], col[19:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_select[0], bus_nibble[4:1], enable_pin[5],
                                   // hold_us[21:6]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    lcd4_cmd_t    cmd;
    lcd4_status_t status;

    assign cfg_ready = 1'b1;

    lcd4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_mode  (s_tdata[2:0]),
        .req_ready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lcd4_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_mode  (s_tdata[2:0]),
        .req_value (s_tdata[10:3]),
        .req_row   (s_tdata[12:11]),
        .req_col   (s_tdata[19:13]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### hw/rtl/lcd4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_checker: port-level checks of the 4-bit character LCD sequencer
// Watches the request and phase streams and flags ordering slips.
// ----------------------------------------------------------------------------
module lcd4_checker
    import lcd4_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic mode_ok;

    assign mode_ok = (s_tdata[2:0] == MODE_CMD) || (s_tdata[2:0] == MODE_DATA) ||
                     (s_tdata[2:0] == MODE_CLEAR) || (s_tdata[2:0] == MODE_CURSOR) ||
                     (s_tdata[2:0] == MODE_INIT);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("master beat dropped while stalled");

    a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("new request taken before final phase");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && mode_ok |=> !s_tready)
        else $error("sequencer ready right after a request");

    a_enable_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> !m_tlast)
        else $error("enable-high phase marked final");

endmodule

bind char_lcd_four_bit_write_sequencer lcd4_checker u_lcd4_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### sim/tb_char_lcd_four_bit_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_four_bit_write_sequencer: self-checking bench of the LCD sequencer
// Streams LCD requests into the block and rebuilds the pin phases each
// accepted request must produce, tracking the timing registers and the held
// select and data pin levels. Every output beat is checked field by field
// under random gaps, random back-pressure, a long sink stall and several
// timing settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_char_lcd_four_bit_write_sequencer;
    import lcd4_pkg::*;

    localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES     = 40;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 30;
    localparam int RANDOM_PER_SET   = 50;
    localparam logic [7:0] CLEAR_BYTE = 8'h01;
    localparam int CLEAR_WAIT_MS      = 2;
    localparam int INIT_STEPS         = 9;
    localparam logic [7:0] INIT_BYTES [INIT_STEPS] =
        '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam int INIT_WAITS [INIT_STEPS] = '{50, 5, 1, 10, 10, 1, 1, 2, 1};

    typedef struct {
        logic [ModeW-1:0] mode;
        logic [7:0]       value;
        logic [1:0]       row;
        logic [6:0]       col;
    } lcd_req_t;

    typedef struct {
        logic             sel;
        logic [3:0]       nib;
        logic             en;
        logic [HoldW-1:0] hold;
        logic             last;
    } pin_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SETUP;
    logic [7:0]  cfg_data = '0;

    lcd_req_t   pending_req_q [$];
    pin_phase_t req_phase_q [$];
    pin_phase_t pin_phase_q [$];

    logic [7:0] model_setup_us  = SETUP_US_RST;
    logic [7:0] model_enable_us = ENABLE_US_RST;
    logic       pin_sel = 1'b0;
    logic [3:0] pin_nib = 4'h0;

    bit s_took = 1'b0;
    bit sink_hold = 1'b0;
    bit sink_hold_req = 1'b0;
    int src_gap_pct = 10;
    int sink_gap_pct = 10;
    int err_count = 0;
    int phases_checked = 0;
    int mode_seen [8] = '{default: 0};

    char_lcd_four_bit_write_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic add_phase(input logic en, input logic [HoldW-1:0] hold);
        pin_phase_t ph;
        ph.sel  = pin_sel;
        ph.nib  = pin_nib;
        ph.en   = en;
        ph.hold = hold;
        ph.last = 1'b0;
        req_phase_q.push_back(ph);
    endtask

    task automatic add_nibble(input logic [3:0] nib, input logic sel);
        pin_sel = sel;
        add_phase(1'b0, HoldW'(model_setup_us));
        pin_nib = nib;
        add_phase(1'b1, HoldW'(model_enable_us));
        add_phase(1'b0, HoldW'(model_enable_us));
    endtask

    task automatic add_byte(input logic [7:0] b, input logic sel);
        add_nibble(b[7:4], sel);
        add_nibble(b[3:0], sel);
    endtask

    task automatic add_wait(input int ms);
        add_phase(1'b0, HoldW'(ms * int'(US_PER_MS)));
    endtask

    task automatic predict_pin_phases(input lcd_req_t req);
        pin_phase_t ph;
        req_phase_q.delete();
        mode_seen[req.mode]++;
        case (req.mode)
            MODE_CMD:    add_byte(req.value, 1'b0);
            MODE_DATA:   add_byte(req.value, 1'b1);
            MODE_CLEAR:
            begin
                add_byte(CLEAR_BYTE, 1'b0);
                add_wait(CLEAR_WAIT_MS);
            end
            MODE_CURSOR: add_byte(ROW_BASE[req.row] | {1'b0, req.col}, 1'b0);
            MODE_INIT:
            begin
                for (int i = 0; i < INIT_STEPS; i++)
                begin
                    add_wait(INIT_WAITS[i]);
                    add_byte(INIT_BYTES[i], 1'b0);
                end
            end
            default: ;
        endcase
        // mark the final phase of this request
        while (req_phase_q.size() != 0)
        begin
            ph = req_phase_q.pop_front();
            if (req_phase_q.size() == 0)
                ph.last = 1'b1;
            pin_phase_q.push_back(ph);
        end
    endtask

    // driver: present the next request, hold it until taken
    always @(negedge clk)
    begin
        lcd_req_t req;
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= src_gap_pct)
            begin
                req = pending_req_q.pop_front();
                s_tdata  <= {4'b0, req.col, req.row, req.value, req.mode};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && !sink_hold && ($urandom_range(99) >= sink_gap_pct);

    // long sink stall, counted here while the driver keeps offering
    always
    begin
        wait (sink_hold_req);
        sink_hold = 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        sink_hold_req = 1'b0;
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge clk)
    begin
        lcd_req_t   req;
        pin_phase_t want;
        s_took = rst_n && s_tvalid && s_tready;
        if (s_took)
        begin
            req.mode  = s_tdata[2:0];
            req.value = s_tdata[10:3];
            req.row   = s_tdata[12:11];
            req.col   = s_tdata[19:13];
            predict_pin_phases(req);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pin_phase_q.size() == 0)
                report_mismatch($sformatf("unexpected beat data %h last %b",
                                          m_tdata, m_tlast));
            else
            begin
                want = pin_phase_q.pop_front();
                if (m_tdata[0] !== want.sel)
                    report_mismatch($sformatf("phase %0d select got %b want %b",
                                              phases_checked, m_tdata[0], want.sel));
                if (m_tdata[4:1] !== want.nib)
                    report_mismatch($sformatf("phase %0d nibble got %h want %h",
                                              phases_checked, m_tdata[4:1], want.nib));
                if (m_tdata[5] !== want.en)
                    report_mismatch($sformatf("phase %0d enable got %b want %b",
                                              phases_checked, m_tdata[5], want.en));
                if (m_tdata[21:6] !== want.hold)
                    report_mismatch($sformatf("phase %0d hold got %0d want %0d",
                                              phases_checked, m_tdata[21:6], want.hold));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("phase %0d last got %b want %b",
                                              phases_checked, m_tlast, want.last));
                phases_checked++;
            end
        end
    end

    task automatic add_request(input logic [ModeW-1:0] mode, input logic [7:0] value,
                               input logic [1:0] row, input logic [6:0] col);
        lcd_req_t req;
        req.mode  = mode;
        req.value = value;
        req.row   = row;
        req.col   = col;
        pending_req_q.push_back(req);
    endtask

    task automatic add_random_requests(input int n);
        int pick;
        logic [ModeW-1:0] mode;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                mode = MODE_DATA;
            else if (pick < 65)
                mode = MODE_CMD;
            else if (pick < 83)
                mode = MODE_CURSOR;
            else if (pick < 93)
                mode = MODE_CLEAR;
            else if (pick < 96)
                mode = MODE_INIT;
            else
                mode = ModeW'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            add_request(mode, 8'($urandom), 2'($urandom), 7'($urandom));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SETUP)
            model_setup_us = val;
        else
            model_enable_us = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain: wait for every request taken and every phase seen, then let
    // ignored requests clear the controller
    task automatic settle();
        while (pending_req_q.size() != 0 || s_tvalid || pin_phase_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed set at reset timing
        add_request(MODE_CMD,    8'h00, 2'd0, 7'd0);
        add_request(MODE_CMD,    8'hFF, 2'd3, 7'd127);
        add_request(MODE_DATA,   8'h00, 2'd0, 7'd0);
        add_request(MODE_DATA,   8'hFF, 2'd3, 7'd127);
        add_request(MODE_DATA,   8'h5A, 2'd1, 7'd42);
        add_request(MODE_CMD,    8'hA5, 2'd2, 7'd85);
        add_request(MODE_CLEAR,  8'hFF, 2'd3, 7'd127);
        add_request(MODE_CURSOR, 8'h00, 2'd0, 7'd0);
        add_request(MODE_CURSOR, 8'h00, 2'd0, 7'd127);
        add_request(MODE_CURSOR, 8'hFF, 2'd1, 7'd127);
        add_request(MODE_CURSOR, 8'h00, 2'd2, 7'd85);
        add_request(MODE_CURSOR, 8'h00, 2'd3, 7'd42);
        add_request(MODE_CURSOR, 8'h00, 2'd3, 7'd127);
        add_request(MODE_INIT,   8'h00, 2'd0, 7'd0);
        add_request(MODE_SPARE_LO, 8'hFF, 2'd3, 7'd127);
        add_request(MODE_DATA,   8'h3C, 2'd0, 7'd0);
        add_request(ModeW'(6),   8'h81, 2'd2, 7'd1);
        add_request(MODE_SPARE_HI, 8'h00, 2'd0, 7'd0);
        add_request(MODE_CMD,    8'h0F, 2'd1, 7'd64);
        settle();

        // slow setup, shortest nonzero enable, with a long sink stall
        write_reg(CFG_SETUP, 8'd255);
        write_reg(CFG_ENABLE, 8'd1);
        add_random_requests(RANDOM_PER_SET);
        @(posedge clk);
        sink_hold_req = 1'b1;
        settle();

        // zero holds, no gaps on either side
        write_reg(CFG_SETUP, 8'd0);
        write_reg(CFG_ENABLE, 8'd0);
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        add_random_requests(RANDOM_PER_SET);
        settle();
        src_gap_pct  = 10;
        sink_gap_pct = 10;

        write_reg(CFG_SETUP, 8'd1);
        write_reg(CFG_ENABLE, 8'd255);
        add_random_requests(RANDOM_PER_SET);
        settle();

        write_reg(CFG_SETUP, 8'($urandom_range(1, 254)));
        write_reg(CFG_ENABLE, 8'($urandom_range(1, 254)));
        add_random_requests(RANDOM_PER_SET);
        settle();

        if (pin_phase_q.size() != 0)
            report_mismatch($sformatf("%0d phases never arrived", pin_phase_q.size()));

        $display("Covered %0d command, %0d data, %0d clear, %0d cursor, %0d init requests",
                 mode_seen[MODE_CMD], mode_seen[MODE_DATA], mode_seen[MODE_CLEAR],
                 mode_seen[MODE_CURSOR], mode_seen[MODE_INIT]);
        $display("plus %0d ignored ones; %0d pin phases checked over five timing sets",
                 mode_seen[5] + mode_seen[6] + mode_seen[7], phases_checked);
        if (err_count == 0)
            $display("tb_char_lcd_four_bit_write_sequencer OK");
        else
            $display("tb_char_lcd_four_bit_write_sequencer NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d phases outstanding", pin_phase_q.size());
        $display("tb_char_lcd_four_bit_write_sequencer NOT OK");
        $finish;
    end

endmodule
